// ===== hdl/sid_pkg.sv =====
// Shared constants, register codes and reset values for the integrate-and-dump averager.
package sid_pkg;

  localparam int DEF_MAX_FRAME_ELEMENTS = 4096;
  localparam int DEF_SAMPLE_BITS        = 48;

  localparam int SUM_W     = 64;
  localparam int FLEN_W    = 13;
  localparam int PERIOD_W  = 17;
  localparam int CAP_W     = 16;
  localparam int IDX_OUT_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATION_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LENGTH     = 2'd2;

  localparam logic [FLEN_W-1:0]   RST_FRAME_LENGTH       = 13'd512;
  localparam logic [PERIOD_W-1:0] RST_INTEGRATION_PERIOD = 17'd1;
  localparam logic [CAP_W-1:0]    RST_CAPTURE_LENGTH     = 16'd1;

endpackage

// ===== hdl/sid_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module sid_divider
  import sid_pkg::*;
#(
  parameter int DVD_W = 64,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] d_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/sid_sum_mem.sv =====
// Per-element running sum store, one write and one registered read port.
module sid_sum_mem
  import sid_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SUM_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [SUM_W-1:0] rdata
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/statistics_integrate_and_dump_core.sv =====
// Integrate-and-dump averager top level: counters, sum update, divide, output word.
// Each input word passes the read, add, divide and output-load states before out_valid rises.
// Input stalls until the bit-serial 64-bit divider has finished and the word is loaded.
// The next input word is taken while a finished word waits in the output register.
// Reset (rst_n, synchronous) clears counters and control and loads register defaults;
// the sum store is not cleared, the first frame of each capture overwrites it.
module statistics_integrate_and_dump_core
  import sid_pkg::*;
#(
  parameter int MAX_FRAME_ELEMENTS = DEF_MAX_FRAME_ELEMENTS,
  parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_value_valid,
  output logic [SAMPLE_BITS-1:0] out_result_value,
  output logic [IDX_OUT_W-1:0]   out_element_index,
  output logic                   out_frame_end,
  output logic                   out_capture_done
);

  localparam int IDX_W = (MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1;
  localparam int CNT_W = PERIOD_W;
  localparam logic [CNT_W-1:0] MAX_FL = CNT_W'(MAX_FRAME_ELEMENTS);

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_ADD, ST_DIV, ST_OUT} state_t;

  state_t state_r, state_nxt;

  logic [FLEN_W-1:0]   frame_length_r;
  logic [PERIOD_W-1:0] period_r;
  logic [CAP_W-1:0]    capture_length_r;

  logic [IDX_W-1:0] elem_ctr_r;
  logic [CAP_W-1:0] frame_ctr_r;

  logic [SAMPLE_BITS-1:0] samp_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       mag_r;
  logic                   neg_r;
  logic                   first_r;
  logic                   fend_r;
  logic                   done_r;
  logic [SUM_W-1:0]       sum_r;

  logic                   out_valid_r;
  logic                   out_value_valid_r;
  logic [SAMPLE_BITS-1:0] out_result_r;
  logic [IDX_OUT_W-1:0]   out_index_r;
  logic                   out_fend_r;
  logic                   out_done_r;

  logic             in_acc;
  logic [CNT_W-1:0] fl_eff;
  logic [CAP_W-1:0] cl_eff;
  logic [CNT_W-1:0] n_c;
  logic [CNT_W-1:0] idx_inc;
  logic             fend_c;
  logic             done_c;
  logic             neg_c;
  logic [CNT_W-1:0] mag_neg;
  logic [CNT_W-1:0] mag_c;

  logic [SUM_W-1:0] rd_data;
  logic [SUM_W:0]   add_full;
  logic [SUM_W-1:0] sum_c;
  logic             div_start;
  logic             div_w_busy;
  logic             div_n_busy;
  logic [SUM_W-1:0] quot_w;
  logic [CNT_W-1:0] rem_w;
  logic [CNT_W-1:0] quot_n;
  logic [CNT_W-1:0] rem_n;
  logic             div_fin;
  logic             dump;
  logic             mem_we;
  logic [SUM_W-1:0] mem_wdata;
  logic             out_free;
  logic [SAMPLE_BITS-1:0] avg_sat;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    if (frame_length_r == '0) begin
      fl_eff = CNT_W'(1);
    end else if (CNT_W'(frame_length_r) > MAX_FL) begin
      fl_eff = MAX_FL;
    end else begin
      fl_eff = CNT_W'(frame_length_r);
    end
  end

  assign cl_eff  = (capture_length_r == '0) ? CAP_W'(1) : capture_length_r;
  assign n_c     = CNT_W'(frame_ctr_r) + CNT_W'(1);
  assign idx_inc = CNT_W'(elem_ctr_r) + CNT_W'(1);
  assign fend_c  = idx_inc >= fl_eff;
  assign done_c  = fend_c && (n_c >= CNT_W'(cl_eff));
  assign neg_c   = period_r[PERIOD_W-1];
  assign mag_neg = ~period_r + CNT_W'(1);
  assign mag_c   = neg_c ? ((mag_neg == '0) ? CNT_W'(cl_eff) : mag_neg)
                         : ((period_r == '0) ? CNT_W'(cl_eff) : period_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r   <= RST_FRAME_LENGTH;
      period_r         <= RST_INTEGRATION_PERIOD;
      capture_length_r <= RST_CAPTURE_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH:       frame_length_r   <= cfg_wdata[FLEN_W-1:0];
        CFG_INTEGRATION_PERIOD: period_r         <= cfg_wdata[PERIOD_W-1:0];
        CFG_CAPTURE_LENGTH:     capture_length_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  sid_sum_mem #(
    .DEPTH (MAX_FRAME_ELEMENTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (elem_ctr_r),
    .rdata (rd_data)
  );

  // saturating accumulate; first frame of a capture overwrites
  assign add_full  = {1'b0, rd_data} + (SUM_W + 1)'(samp_r);
  assign sum_c     = first_r ? SUM_W'(samp_r) :
                     (add_full[SUM_W] ? {SUM_W{1'b1}} : add_full[SUM_W-1:0]);
  assign div_start = (state_r == ST_ADD);

  sid_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sum_c),
    .divisor   (mag_r),
    .busy      (div_w_busy),
    .quotient  (quot_w),
    .remainder (rem_w)
  );

  sid_divider #(
    .DVD_W (CNT_W),
    .DVS_W (CNT_W)
  ) u_div_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (mag_r),
    .busy      (div_n_busy),
    .quotient  (quot_n),
    .remainder (rem_n)
  );

  assign div_fin   = (state_r == ST_DIV) && !div_w_busy && !div_n_busy;
  assign dump      = (rem_n == '0);
  assign mem_we    = div_fin;
  assign mem_wdata = dump ? '0 : sum_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign avg_sat   = ((quot_w >> SAMPLE_BITS) != '0) ? {SAMPLE_BITS{1'b1}}
                                                     : SAMPLE_BITS'(quot_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DIV;
      ST_DIV:  if (div_fin) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state, counters and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elem_ctr_r  <= '0;
      frame_ctr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (fend_c) begin
          elem_ctr_r  <= '0;
          frame_ctr_r <= done_c ? '0 : n_c[CAP_W-1:0];
        end else begin
          elem_ctr_r <= idx_inc[IDX_W-1:0];
        end
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r       <= 1'b1;
        out_value_valid_r <= dump;
        out_result_r      <= !dump ? '0 : (neg_r ? samp_r : avg_sat);
        out_index_r       <= IDX_OUT_W'(idx_r);
        out_fend_r        <= fend_r;
        out_done_r        <= done_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r  <= in_sample_value;
      idx_r   <= elem_ctr_r;
      n_r     <= n_c;
      mag_r   <= mag_c;
      neg_r   <= neg_c;
      first_r <= (frame_ctr_r == '0);
      fend_r  <= fend_c;
      done_r  <= done_c;
    end
    if (state_r == ST_ADD) begin
      sum_r <= sum_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_valid   = out_value_valid_r;
  assign out_result_value  = out_result_r;
  assign out_element_index = out_index_r;
  assign out_frame_end     = out_fend_r;
  assign out_capture_done  = out_done_r;

`ifndef ASSERT_OFF
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("output word loaded outside output state");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!div_w_busy && !div_n_busy))
    else $error("divider busy while idle");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_fin |-> ((rem_w < mag_r) && (rem_n < mag_r) && (quot_n <= n_r)))
    else $error("divider result out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fend_c) |=> (elem_ctr_r == '0))
    else $error("element counter did not wrap at frame end");

  a_done_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_fend_r)
    else $error("capture done without frame end");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_value_valid_r |-> (out_result_r == '0))
    else $error("result nonzero without value valid");
`endif

endmodule

// ===== test/statistics_integrate_and_dump_core_tb.sv =====
// Testbench for the integrate-and-dump averager: directed and random words checked against a predictor.
module statistics_integrate_and_dump_core_tb;
  import sid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_EL     = DEF_MAX_FRAME_ELEMENTS;
  localparam logic [47:0] SAMPLE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int          LIMIT      = 600000;
  localparam int          HOLD_LEN   = 400;

  typedef struct packed {
    logic        value_valid;
    logic [47:0] result_value;
    logic [11:0] element_index;
    logic        frame_end;
    logic        capture_done;
  } avg_word_t;

  typedef enum {MODE_MIX, MODE_PEAK, MODE_EDGE} fill_mode_t;

  class avg_scoreboard;
    bit [63:0]           elem_sums [MAX_EL];
    int unsigned         elem_cnt;
    int unsigned         frame_cnt;
    int                  top_written;
    logic [FLEN_W-1:0]   flen;
    logic [PERIOD_W-1:0] period;
    logic [CAP_W-1:0]    caplen;
    avg_word_t           due_words [$];
    int                  errors;

    function new();
      elem_cnt    = 0;
      frame_cnt   = 0;
      top_written = -1;
      errors      = 0;
      flen        = RST_FRAME_LENGTH;
      period      = RST_INTEGRATION_PERIOD;
      caplen      = RST_CAPTURE_LENGTH;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_FRAME_LENGTH:       flen   = data[FLEN_W-1:0];
        CFG_INTEGRATION_PERIOD: period = data[PERIOD_W-1:0];
        CFG_CAPTURE_LENGTH:     caplen = data[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // largest effective frame length that never reads an unwritten sum
    function int safe_flen();
      return (frame_cnt == 0) ? 8191 : top_written + 1;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void note_sample(logic [47:0] s);
      int unsigned fl, cl, n, idx, mag;
      bit          neg;
      bit [63:0]   sum;
      bit [63:0]   quot;
      avg_word_t   w;
      fl  = (flen == 0) ? 1 : flen;
      if (fl > MAX_EL) fl = MAX_EL;
      cl  = (caplen == 0) ? 1 : caplen;
      n   = frame_cnt + 1;
      idx = (elem_cnt >= MAX_EL) ? MAX_EL - 1 : elem_cnt;
      neg = period[16];
      mag = neg ? ((32'h20000 - {15'd0, period}) & 32'h1FFFF) : {15'd0, period};
      if (mag == 0) mag = cl;
      if (frame_cnt == 0) begin
        sum = {16'd0, s};
      end else begin
        sum = elem_sums[idx];
        sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - {16'd0, s}) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : sum + {16'd0, s};
      end
      w = '0;
      if (n % mag == 0) begin
        w.value_valid = 1'b1;
        if (!neg) begin
          quot = sum / {32'd0, mag};
          w.result_value = (quot > {16'd0, SAMPLE_MAX}) ? SAMPLE_MAX : quot[47:0];
        end else begin
          w.result_value = s;
        end
        sum = '0;
      end
      elem_sums[idx] = sum;
      if (int'(idx) > top_written) top_written = idx;
      w.element_index = idx[11:0];
      w.frame_end     = (idx + 1 >= fl);
      if (w.frame_end) begin
        elem_cnt = 0;
        if (n >= cl) begin
          w.capture_done = 1'b1;
          frame_cnt = 0;
        end else begin
          frame_cnt = n & 32'hFFFF;
        end
      end else begin
        elem_cnt = idx + 1;
      end
      due_words.push_back(w);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(avg_word_t got);
      avg_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 100) $display("%0t: unexpected result word %h", $time, got);
        return;
      end
      want = due_words.pop_front();
      cmp("value_valid", 64'(want.value_valid), 64'(got.value_valid));
      cmp("result_value", 64'(want.result_value), 64'(got.result_value));
      cmp("element_index", 64'(want.element_index), 64'(got.element_index));
      cmp("frame_end", 64'(want.frame_end), 64'(got.frame_end));
      cmp("capture_done", 64'(want.capture_done), 64'(got.capture_done));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [47:0]          in_sample_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_value_valid;
  logic [47:0]          out_result_value;
  logic [11:0]          out_element_index;
  logic                 out_frame_end;
  logic                 out_capture_done;

  avg_scoreboard sb;
  bit            steady = 1'b0;
  int            hold_seq = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            words_sent = 0;
  int            cycles = 0;

  statistics_integrate_and_dump_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_valid   (out_value_valid),
    .out_result_value  (out_result_value),
    .out_element_index (out_element_index),
    .out_frame_end     (out_frame_end),
    .out_capture_done  (out_capture_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("statistics_integrate_and_dump_core_tb failed");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(avg_word_t'{out_value_valid, out_result_value, out_element_index,
                                  out_frame_end, out_capture_done});
  end

  function automatic logic [47:0] next_sample(fill_mode_t mode, int i);
    case (mode)
      MODE_PEAK: return SAMPLE_MAX;
      MODE_EDGE: return i[0] ? SAMPLE_MAX : 48'd0;
      default: begin
        case ($urandom_range(9))
          0: return 48'd0;
          1: return SAMPLE_MAX;
          2: return 48'($urandom_range(255));
          default: return 48'({$urandom, $urandom});
        endcase
      end
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_word(input logic [47:0] v);
    in_valid        <= 1'b1;
    in_sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(v);
    words_sent++;
  endtask

  // send a burst of words, then wait until every result is back
  task automatic run_phase(input int count, input fill_mode_t mode);
    cfg_we <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (!steady && $urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      send_word(next_sample(mode, i));
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_config();
    bit [2:0]             pick;
    logic [CFG_DAT_W-1:0] v;
    int                   fl_eff;
    pick = 3'($urandom_range(1, 7));
    if (pick[0]) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v = 17'($urandom_range(1, 6));
        6:                v = 17'($urandom_range(7, 40));
        7:                v = 17'd0;
        8:                v = ($urandom_range(1)) ? 17'd4096 : 17'($urandom_range(4097, 8191));
        default:          v = 17'($urandom_range(41, 300));
      endcase
      fl_eff = (v == 0) ? 1 : ((v > MAX_EL) ? MAX_EL : int'(v));
      if (fl_eff > sb.safe_flen()) v = 17'(sb.safe_flen());
      cfg_write(CFG_FRAME_LENGTH, v);
    end
    if (pick[1]) begin
      case ($urandom_range(11))
        0, 1, 2, 3: v = 17'($urandom_range(1, 4));
        4, 5, 6:    v = 17'(-$urandom_range(1, 4));
        7:          v = 17'd0;
        8:          v = 17'h0FFFF;
        9:          v = 17'h10000;
        default:    v = 17'($urandom);
      endcase
      cfg_write(CFG_INTEGRATION_PERIOD, v);
    end
    if (pick[2]) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v = 17'($urandom_range(1, 8));
        6:                v = 17'd0;
        7:                v = 17'hFFFF;
        default:          v = 17'($urandom_range(9, 40));
      endcase
      cfg_write(CFG_CAPTURE_LENGTH, v);
    end
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, then a frame cut short by a smaller frame length
    run_phase(2, MODE_EDGE);
    cfg_write(CFG_FRAME_LENGTH, 17'd2);
    run_phase(1, MODE_MIX);

    // zero frame and capture lengths, period of -1
    cfg_write(CFG_FRAME_LENGTH, 17'd0);
    cfg_write(CFG_INTEGRATION_PERIOD, 17'h1FFFF);
    cfg_write(CFG_CAPTURE_LENGTH, 17'd0);
    run_phase(2, MODE_EDGE);

    // plain averaging with a partial period dropped at capture end
    cfg_write(CFG_FRAME_LENGTH, 17'd2);
    cfg_write(CFG_INTEGRATION_PERIOD, 17'd2);
    cfg_write(CFG_CAPTURE_LENGTH, 17'd3);
    run_phase(6, MODE_MIX);

    // period shortened mid-capture: average saturates; capture length lowered mid-capture
    cfg_write(CFG_FRAME_LENGTH, 17'd1);
    cfg_write(CFG_INTEGRATION_PERIOD, 17'd4);
    cfg_write(CFG_CAPTURE_LENGTH, 17'd8);
    run_phase(3, MODE_PEAK);
    cfg_write(CFG_INTEGRATION_PERIOD, 17'd1);
    run_phase(1, MODE_PEAK);
    cfg_write(CFG_CAPTURE_LENGTH, 17'd2);
    run_phase(1, MODE_MIX);

    // zero period means capture length
    cfg_write(CFG_FRAME_LENGTH, 17'd2);
    cfg_write(CFG_INTEGRATION_PERIOD, 17'd0);
    cfg_write(CFG_CAPTURE_LENGTH, 17'd2);
    run_phase(4, MODE_MIX);

    // period -65536, oversized frame length, longest capture
    cfg_write(CFG_INTEGRATION_PERIOD, 17'h10000);
    cfg_write(CFG_FRAME_LENGTH, 17'd8191);
    cfg_write(CFG_CAPTURE_LENGTH, 17'hFFFF);
    run_phase(3, MODE_MIX);
    cfg_write(CFG_FRAME_LENGTH, 17'd1);
    run_phase(1, MODE_MIX);

    phase = 0;
    while (words_sent < 550) begin
      steady = (phase >= 6 && phase < 10);
      random_config();
      if (phase == 3) begin
        hold_seq++;
        run_phase(30, MODE_MIX);
      end else begin
        run_phase($urandom_range(8, 40), MODE_MIX);
      end
      phase++;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("statistics_integrate_and_dump_core_tb passed");
    else
      $display("statistics_integrate_and_dump_core_tb failed");
    $finish;
  end

endmodule
